FILE: hw/rtl/sxpf_pkg.sv
// shared types and constants of the seven-bit packing framer
`timescale 1ns / 1ps

package sxpf_pkg;

  localparam logic [7:0] SOF_BYTE      = 8'hF0;
  localparam logic [7:0] MSG_TYPE_BYTE = 8'h01;
  localparam logic [7:0] CHECKSUM_BYTE = 8'h00;
  localparam logic [7:0] EOF_BYTE      = 8'hF7;

  localparam logic [2:0] GROUP_SIZE   = 3'd7;
  localparam logic [2:0] HDR_LAST_IDX = 3'd5;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [7:0] seq_number;
    logic [7:0] cmd_code;
    logic [7:0] sub_code;
    logic [7:0] payload_byte;
    logic       has_byte;
    logic       last_item;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       frame_end;
    logic       run_end;
  } out_t;

  // classified request handed from front to back
  typedef struct packed {
    logic       hdr;
    logic       has;
    logic       last;
    logic [7:0] seq;
    logic [7:0] cmd;
    logic [7:0] sub;
    logic [7:0] payload;
  } op_t;

  typedef struct packed {
    logic valid;
    logic ready;
  } q_status_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_HDR,
    B_HI,
    B_LO,
    B_END
  } back_state_t;

endpackage

FILE: hw/rtl/sxpf_front.sv
// front end: accepts requests, tracks frame open state, classifies them
`timescale 1ns / 1ps

module sxpf_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  sxpf_pkg::in_t       in_data,
  input  sxpf_pkg::q_status_t q_st,
  output logic                push,
  output sxpf_pkg::op_t       push_op
);
  import sxpf_pkg::*;

  logic in_msg_r;
  logic in_msg_nxt;
  logic accept;
  logic keep;

  assign in_stall = !q_st.ready;
  assign accept   = in_valid && q_st.ready;

  // an open-frame request with no byte and no end has no effect at all
  assign keep = !in_msg_r || in_data.has_byte || in_data.last_item;
  assign push = accept && keep;

  always_comb begin
    push_op.hdr     = !in_msg_r;
    push_op.has     = in_data.has_byte;
    push_op.last    = in_data.last_item;
    push_op.seq     = in_data.seq_number;
    push_op.cmd     = in_data.cmd_code;
    push_op.sub     = in_data.sub_code;
    push_op.payload = in_data.payload_byte;
  end

  always_comb begin
    in_msg_nxt = in_msg_r;
    if (accept) begin
      in_msg_nxt = !in_data.last_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_msg_r <= 1'b0;
    end else begin
      in_msg_r <= in_msg_nxt;
    end
  end

endmodule

FILE: hw/rtl/sxpf_queue.sv
// small fifo of classified requests between front and back
`timescale 1ns / 1ps

module sxpf_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  sxpf_pkg::op_t       push_op,
  input  logic                pop,
  output sxpf_pkg::q_status_t q_st,
  output sxpf_pkg::op_t       head_op
);
  import sxpf_pkg::*;

  op_t               mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  assign q_st.valid = (cnt_r != '0);
  assign q_st.ready = (cnt_r != QCNT_W'(QUEUE_DEPTH));
  assign head_op    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

FILE: hw/rtl/sxpf_back.sv
// back end: group packing and byte sequencer with output register
`timescale 1ns / 1ps

module sxpf_back (
  input  logic                clk,
  input  logic                rst_n,
  input  sxpf_pkg::q_status_t q_st,
  input  sxpf_pkg::op_t       head_op,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output sxpf_pkg::out_t      out_data
);
  import sxpf_pkg::*;

  back_state_t state_r, state_nxt;

  op_t         op_r;
  logic        flush_r;
  logic [2:0]  fl_n_r;
  logic [6:0]  fl_hi_r;
  logic [2:0]  cnt_r, cnt_nxt;
  logic [6:0]  hi_r, hi_nxt;
  logic [2:0]  idx_r, idx_nxt;
  logic [6:0]  lo_r [GROUP_SIZE];

  logic        out_valid_r, out_valid_nxt;
  out_t        out_data_r, out_data_nxt;

  logic        start;
  logic [2:0]  base_cnt;
  logic [6:0]  base_hi;
  logic [6:0]  st_hi;
  logic [2:0]  st_cnt;
  logic        st_flush;

  logic        emit;
  logic        emit_ok;
  logic        fire;
  logic        last_step;
  out_t        emit_data;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign start = (state_r == B_IDLE) && q_st.valid;
  assign pop   = start;

  // store the new byte into the group; a new frame starts from an empty group
  always_comb begin
    base_cnt = head_op.hdr ? 3'd0 : cnt_r;
    base_hi  = head_op.hdr ? 7'd0 : hi_r;
    st_hi    = base_hi;
    st_cnt   = base_cnt;
    if (head_op.has) begin
      st_hi  = base_hi | (7'(head_op.payload[7]) << base_cnt);
      st_cnt = base_cnt + 3'd1;
    end
    st_flush = (head_op.has && (st_cnt == GROUP_SIZE)) ||
               (head_op.last && (st_cnt != 3'd0));
  end

  always_comb begin
    cnt_nxt = cnt_r;
    hi_nxt  = hi_r;
    if (start) begin
      cnt_nxt = st_flush ? 3'd0 : st_cnt;
      hi_nxt  = st_flush ? 7'd0 : st_hi;
    end
  end

  assign emit_ok = !out_valid_r || !out_stall;
  assign fire    = emit && emit_ok;

  // output decode per sequencer state
  always_comb begin
    emit      = 1'b0;
    last_step = 1'b0;
    emit_data = '0;
    unique case (state_r)
      B_IDLE: begin
        emit = 1'b0;
      end
      B_HDR: begin
        emit      = 1'b1;
        last_step = (idx_r == HDR_LAST_IDX);
        unique case (idx_r)
          3'd0:    emit_data.out_byte = SOF_BYTE;
          3'd1:    emit_data.out_byte = MSG_TYPE_BYTE;
          3'd2:    emit_data.out_byte = op_r.seq;
          3'd3:    emit_data.out_byte = CHECKSUM_BYTE;
          3'd4:    emit_data.out_byte = op_r.cmd;
          default: emit_data.out_byte = op_r.sub;
        endcase
        emit_data.run_end = last_step && !flush_r && !op_r.last;
      end
      B_HI: begin
        emit      = 1'b1;
        last_step = 1'b1;
        emit_data.out_byte = {1'b0, fl_hi_r};
      end
      B_LO: begin
        emit      = 1'b1;
        last_step = (idx_r == (fl_n_r - 3'd1));
        emit_data.out_byte = {1'b0, lo_r[idx_r]};
        emit_data.run_end  = last_step && !op_r.last;
      end
      B_END: begin
        emit      = 1'b1;
        last_step = 1'b1;
        emit_data.out_byte  = EOF_BYTE;
        emit_data.frame_end = 1'b1;
        emit_data.run_end   = 1'b1;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE: begin
        if (start) begin
          if (head_op.hdr) begin
            state_nxt = B_HDR;
          end else if (st_flush) begin
            state_nxt = B_HI;
          end else if (head_op.last) begin
            state_nxt = B_END;
          end
        end
      end
      B_HDR: begin
        if (fire && last_step) begin
          if (flush_r) begin
            state_nxt = B_HI;
          end else if (op_r.last) begin
            state_nxt = B_END;
          end else begin
            state_nxt = B_IDLE;
          end
        end
      end
      B_HI: begin
        if (fire) begin
          state_nxt = B_LO;
        end
      end
      B_LO: begin
        if (fire && last_step) begin
          state_nxt = op_r.last ? B_END : B_IDLE;
        end
      end
      B_END: begin
        if (fire) begin
          state_nxt = B_IDLE;
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  always_comb begin
    idx_nxt = idx_r;
    if (start) begin
      idx_nxt = 3'd0;
    end else if (fire) begin
      idx_nxt = last_step ? 3'd0 : idx_r + 3'd1;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    if (fire) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = emit_data;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      op_r    <= head_op;
      flush_r <= st_flush;
      fl_n_r  <= st_cnt;
      fl_hi_r <= st_hi;
      if (head_op.has) begin
        lo_r[base_cnt] <= head_op.payload[6:0];
      end
    end
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      cnt_r       <= 3'd0;
      hi_r        <= 7'd0;
      idx_r       <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      hi_r        <= hi_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_lo_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_LO) |-> ((fl_n_r != 3'd0) && (idx_r < fl_n_r)))
    else $error("group index past flush length");

  a_group_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_IDLE) |-> (cnt_r < GROUP_SIZE))
    else $error("full group left unflushed");

  a_hi_then_lo: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_HI && fire) |=> (state_r == B_LO && idx_r == 3'd0))
    else $error("top-bit byte not followed by group bytes");

  a_eof_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_END && fire) |=> (out_valid_r && out_data_r.frame_end &&
                                    out_data_r.out_byte == EOF_BYTE))
    else $error("closing byte not registered");

  a_end_is_run_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.frame_end) |-> out_data_r.run_end)
    else $error("frame end without run end");

endmodule

FILE: hw/rtl/sysex_seven_bit_packing_framer_core.sv
// top level of the seven-bit packing framer
`timescale 1ns / 1ps

// Frames a message for a SysEx-style link: the first request of a message
// yields the header F0 01 seq 00 cmd sub, payload bytes are packed in groups
// of up to seven (a byte of top bits, then those bytes with bit 7 cleared) and
// the last request closes the frame with F7. The front end takes a request
// in any cycle the two-entry request queue has room; the back end picks up
// a queued request only while idle and then emits its bytes, one per cycle
// while the output does not stall, before it picks up the next; a request
// yields 0 to 9 bytes, so the output byte rate sets the throughput.
// A request that only fills a group slot emits no byte.

module sysex_seven_bit_packing_framer_core (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  sxpf_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output sxpf_pkg::out_t out_data
);
  import sxpf_pkg::*;

  q_status_t q_st;
  logic      push;
  logic      pop;
  op_t       push_op;
  op_t       head_op;

  sxpf_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_st     (q_st),
    .push     (push),
    .push_op  (push_op)
  );

  sxpf_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_op (push_op),
    .pop     (pop),
    .q_st    (q_st),
    .head_op (head_op)
  );

  sxpf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_st      (q_st),
    .head_op   (head_op),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
